// ===== sv/oale_pkg.sv =====
// package: sizes, action codes, controller states and shared structs for the list engine
`default_nettype none
package oale_pkg;

  localparam int unsigned CAPACITY  = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned OUT_CNT_W = 8;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned GRP_SZ    = 8;
  localparam int unsigned NUM_GRP   = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  localparam int unsigned IN_RAW_W  = ACT_W + POS_W + DATA_W;
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W = DATA_W + 1 + OUT_CNT_W + 1;
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_W - OUT_RAW_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } ctrl_state_e;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 load;
    logic                 ok;
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/ordered_array_list_engine_core.sv =====
// ordered list engine top level: cell row, read reduction and result register
//
// Usage: each input item on the s_axis channel carries an action (insert before a
// 1-based position, delete at a position, read at a position, clear), a position
// and a value; each item gives exactly one result item on the m_axis channel with
// the read value (zero unless a read succeeds), an ok flag, the length after the
// action and an empty flag. Failed actions leave the list untouched.
// The result passes the registered group-select stage and then the result
// register; a new item is not taken while the controller is in its reduce
// state. Inserts and deletes shift every cell of the row in the accepting
// cycle, and the group-select stage picks a read element out of the cell row.
// While a finished result still waits, the next item is taken only in a cycle in
// which that result is taken too, so the result register is free when it reloads.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending
// result; cell contents are not cleared and cannot be reached until rewritten.
// A stalled receiver (m_axis_tready_i low) holds the result steady and blocks
// new input items until the result is taken.
`default_nettype none
module ordered_array_list_engine_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // action[1:0], position[9:2], value[41:10], zero pad above
  input  wire  [oale_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  // read_value[31:0], ok[32], count[40:33], empty_res[41], zero pad above
  output logic [oale_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import oale_pkg::*;

  logic [ACT_W-1:0]  in_action;
  logic [POS_W-1:0]  in_position;
  logic [DATA_W-1:0] in_value;
  cell_ctrl_t        cell_ctrl;
  res_t              res;
  logic              out_hold;

  logic [DATA_W-1:0] elem [CAPACITY];
  logic [DATA_W-1:0] rd   [CAPACITY];
  logic [DATA_W-1:0] grp_d [NUM_GRP];
  logic [DATA_W-1:0] grp_q [NUM_GRP];
  logic [DATA_W-1:0] read_val;

  logic                 m_valid_q, m_valid_d;
  logic [DATA_W-1:0]    m_rv_q;
  logic                 m_ok_q;
  logic [OUT_CNT_W-1:0] m_cnt_q;
  logic                 m_empty_q;

  assign in_action   = s_axis_tdata_i[ACT_W-1:0];
  assign in_position = s_axis_tdata_i[ACT_W+POS_W-1:ACT_W];
  assign in_value    = s_axis_tdata_i[ACT_W+POS_W+DATA_W-1:ACT_W+POS_W];
  assign out_hold    = m_valid_q && !m_axis_tready_i;

  oale_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .action_i    (in_action),
    .position_i  (in_position),
    .value_i     (in_value),
    .out_hold_i  (out_hold),
    .s_ready_o   (s_axis_tready_o),
    .cell_ctrl_o (cell_ctrl),
    .res_o       (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = elem[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = elem[i+1];
    end
    oale_cell u_cell (
      .clk_i   (clk_i),
      .num_i   (CMP_W'(i + 1)),
      .ctrl_i  (cell_ctrl),
      .left_i  (left),
      .right_i (right),
      .elem_o  (elem[i]),
      .rd_o    (rd[i])
    );
  end

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if (g * GRP_SZ + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | rd[g*GRP_SZ+j];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    read_val = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      read_val = read_val | grp_q[g];
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (res.load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      m_rv_q    <= read_val;
      m_ok_q    <= res.ok;
      m_cnt_q   <= res.count;
      m_empty_q <= res.empty;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, m_empty_q, m_cnt_q, m_ok_q, m_rv_q};

`ifndef SYNTHESIS
  a_no_accept_over_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !out_hold)
    else $error("item accepted while result register is held");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second item accepted during reduction");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> ##1 m_axis_tvalid_o)
    else $error("no result two cycles after accept");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_empty_q == (m_cnt_q == '0)))
    else $error("empty flag disagrees with count");

  a_failed_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_ok_q) |-> (m_rv_q == '0))
    else $error("failed action returned a non-zero value");
`endif

endmodule
`default_nettype wire

// ===== sv/oale_cell.sv =====
// one list cell: holds an element and shifts it to or from its neighbours
`default_nettype none
module oale_cell (
  input  wire                         clk_i,
  input  wire  [oale_pkg::CMP_W-1:0]  num_i,
  input  oale_pkg::cell_ctrl_t        ctrl_i,
  input  wire  [oale_pkg::DATA_W-1:0] left_i,
  input  wire  [oale_pkg::DATA_W-1:0] right_i,
  output logic [oale_pkg::DATA_W-1:0] elem_o,
  output logic [oale_pkg::DATA_W-1:0] rd_o
);
  import oale_pkg::*;

  logic [DATA_W-1:0] elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.ins) begin
      if (num_i == ctrl_i.pos) begin
        elem_d = ctrl_i.value;
      end else if (num_i > ctrl_i.pos) begin
        elem_d = left_i;
      end
    end else if (ctrl_i.del && (num_i >= ctrl_i.pos)) begin
      elem_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;
  assign rd_o   = (ctrl_i.rd && (num_i == ctrl_i.pos)) ? elem_q : '0;

endmodule
`default_nettype wire

// ===== sv/oale_ctrl.sv =====
// controller: length register, action checks and item sequencing
`default_nettype none
module oale_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_valid_i,
  input  wire  [oale_pkg::ACT_W-1:0]  action_i,
  input  wire  [oale_pkg::POS_W-1:0]  position_i,
  input  wire  [oale_pkg::DATA_W-1:0] value_i,
  input  wire                         out_hold_i,
  output logic                        s_ready_o,
  output oale_pkg::cell_ctrl_t        cell_ctrl_o,
  output oale_pkg::res_t              res_o
);
  import oale_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ok_q, ok_d;
  logic             accept;
  logic             ok;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             pos_nz, in_list;

  assign pos_x   = CMP_W'(position_i);
  assign cnt_x   = CMP_W'(count_q);
  assign pos_nz  = (pos_x != '0);
  assign in_list = pos_nz && (pos_x <= cnt_x);

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    res_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = !out_hold_i;
        if (s_valid_i && !out_hold_i) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        res_o.load = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_o.ok    = ok_q;
    res_o.count = OUT_CNT_W'(count_q);
    res_o.empty = (count_q == '0);
  end

  assign accept = s_valid_i && s_ready_o;

  always_comb begin
    ok          = 1'b0;
    count_d     = count_q;
    cell_ctrl_o = '0;
    cell_ctrl_o.pos   = pos_x;
    cell_ctrl_o.value = value_i;
    unique case (action_e'(action_i))
      ACT_INSERT: begin
        ok = (count_q != CNT_W'(CAPACITY)) && pos_nz && (pos_x <= (cnt_x + CMP_W'(1)));
        cell_ctrl_o.ins = accept && ok;
        if (accept && ok) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        ok = in_list;
        cell_ctrl_o.del = accept && ok;
        if (accept && ok) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      ACT_READ: begin
        ok = in_list;
        cell_ctrl_o.rd = accept && ok;
      end
      ACT_CLEAR: begin
        ok = 1'b1;
        if (accept) begin
          count_d = '0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign ok_d = accept ? ok : ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

endmodule
`default_nettype wire

// ===== sim/list_result_checker.sv =====
// list engine checker: predicts each result from accepted items and compares it
`timescale 1ns / 1ps
module list_result_checker (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_tvalid_i,
  input  wire                       s_tready_i,
  // action[1:0], position[9:2], value[41:10], zero pad above
  input  wire [oale_pkg::IN_W-1:0]  s_tdata_i,
  input  wire                       m_tvalid_i,
  input  wire                       m_tready_i,
  // read_value[31:0], ok[32], count[40:33], empty_res[41], zero pad above
  input  wire [oale_pkg::OUT_W-1:0] m_tdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import oale_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]    read_value;
    logic                 ok;
    logic [OUT_CNT_W-1:0] count;
    logic                 empty_res;
  } list_result_t;

  logic [DATA_W-1:0] elements [CAPACITY];
  int                list_len;
  int                errors;
  list_result_t      expected_results [$];

  function automatic list_result_t apply_list_action(action_e act, int pos,
                                                     logic [DATA_W-1:0] val);
    list_result_t r;
    r = '0;
    case (act)
      ACT_INSERT: begin
        if (list_len < CAPACITY && pos >= 1 && pos <= list_len + 1) begin
          for (int k = list_len; k >= pos; k--) elements[k] = elements[k-1];
          elements[pos-1] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (list_len > 0 && pos >= 1 && pos <= list_len) begin
          for (int k = pos; k < list_len; k++) elements[k-1] = elements[k];
          list_len--;
          r.ok = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos >= 1 && pos <= list_len) begin
          r.read_value = elements[pos-1];
          r.ok = 1'b1;
        end
      end
      default: begin
        list_len = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count     = OUT_CNT_W'(list_len);
    r.empty_res = (list_len == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      errors   = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.read_value = m_tdata_i[DATA_W-1:0];
        got.ok         = m_tdata_i[DATA_W];
        got.count      = m_tdata_i[DATA_W+OUT_CNT_W:DATA_W+1];
        got.empty_res  = m_tdata_i[DATA_W+OUT_CNT_W+1];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          compare_field("read_value", want.read_value, got.read_value);
          compare_field("ok", want.ok, got.ok);
          compare_field("count", want.count, got.count);
          compare_field("empty_res", want.empty_res, got.empty_res);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(apply_list_action(action_e'(s_tdata_i[ACT_W-1:0]),
                                                     int'(s_tdata_i[ACT_W+POS_W-1:ACT_W]),
                                                     s_tdata_i[IN_RAW_W-1:ACT_W+POS_W]));
      end
      fail_count_o <= errors;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// ===== sim/ordered_array_list_engine_core_test.sv =====
// list engine testbench top: clock, reset, item stimulus and verdict
`timescale 1ns / 1ps
module ordered_array_list_engine_core_test;
  import oale_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tready = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire  [OUT_W-1:0] m_tdata;
  int               fail_count;
  int               pending;
  int               cycles = 0;
  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  int               shadow_len = 0;
  bit               filling = 1'b1;

  always #1 clk_i = ~clk_i;

  ordered_array_list_engine_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  list_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ordered_array_list_engine_core] ERROR");
      $finish;
    end
  end

  task automatic send_item(action_e act, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({val, pos, act});
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    case (act)
      ACT_INSERT: if (shadow_len < CAPACITY && pos >= 1 && pos <= shadow_len + 1) shadow_len++;
      ACT_DELETE: if (pos >= 1 && pos <= shadow_len) shadow_len--;
      ACT_CLEAR:  shadow_len = 0;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly the ends of the range, since shifts hurt most there
  function automatic logic [POS_W-1:0] pick_pos(int hi);
    if (hi == 0) return POS_W'(1);
    case ($urandom_range(0, 3))
      0:       return POS_W'(1);
      1:       return POS_W'(hi);
      default: return POS_W'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic random_item();
    action_e          act;
    logic [POS_W-1:0] pos;
    int unsigned      dice;
    dice = $urandom_range(0, 99);
    if ($urandom_range(0, 149) == 0) begin
      act = ACT_CLEAR;
      pos = POS_W'($urandom_range(0, 255));
    end else if (dice < 15) begin
      act = action_e'($urandom_range(0, 2));
      pos = POS_W'($urandom_range(0, 255));
    end else if (dice < 27) begin
      act = ACT_READ;
      pos = pick_pos(shadow_len);
    end else if (filling) begin
      act = ACT_INSERT;
      pos = pick_pos(shadow_len + 1);
    end else begin
      act = ACT_DELETE;
      pos = pick_pos(shadow_len);
    end
    send_item(act, pos, rand_word());
    if (filling && shadow_len == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if (!filling && shadow_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    else if ($urandom_range(0, 299) == 0) filling = !filling;
  endtask

  initial begin
    snd_idle_pct = 32;
    rcv_idle_pct = 51;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, bad positions, value extremes
    send_item(ACT_READ,   8'd1,   32'h1234_5678);
    send_item(ACT_DELETE, 8'd1,   32'h0);
    send_item(ACT_INSERT, 8'd0,   32'h1);
    send_item(ACT_INSERT, 8'd2,   32'h2);
    send_item(ACT_INSERT, 8'd1,   32'h7FFF_FFFF);
    send_item(ACT_INSERT, 8'd1,   32'h8000_0000);
    send_item(ACT_INSERT, 8'd3,   32'h0);
    send_item(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 8'd2,   32'hFFFF_FFFF);
    send_item(ACT_READ,   8'd1,   32'h0);
    send_item(ACT_READ,   8'd4,   32'h0);
    send_item(ACT_READ,   8'd5,   32'h0);
    send_item(ACT_READ,   8'd0,   32'h0);
    send_item(ACT_READ,   8'd255, 32'h0);
    send_item(ACT_DELETE, 8'd5,   32'h0);
    send_item(ACT_DELETE, 8'd0,   32'h0);
    send_item(ACT_DELETE, 8'd2,   32'h0);
    send_item(ACT_READ,   8'd2,   32'h0);
    send_item(ACT_DELETE, 8'd3,   32'h0);
    send_item(ACT_READ,   8'd1,   32'h0);
    send_item(ACT_CLEAR,  8'd0,   32'hFFFF_FFFF);
    send_item(ACT_READ,   8'd1,   32'h0);
    send_item(ACT_DELETE, 8'd1,   32'h0);
    send_item(ACT_CLEAR,  8'd255, 32'h0);
    send_item(ACT_INSERT, 8'd1,   32'h5A5A_5A5A);
    send_item(ACT_READ,   8'd1,   32'h0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin snd_idle_pct = 32; rcv_idle_pct = 51; end
        1:       begin snd_idle_pct = 51; rcv_idle_pct = 32; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      repeat (600) random_item();
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ordered_array_list_engine_core] OK");
    end else begin
      $display("[ordered_array_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule
